### design/saq_pkg.sv
// saq_pkg: constants, types and per-stage step functions for the shortest-arc
// quaternion pipeline; no dependencies
`default_nettype none
package saq_pkg;

    localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
    localparam logic [30:0] COS_LIMIT = 31'd1073740750;

    // case codes on tuser
    localparam logic [1:0] CASE_GENERAL = 2'd0;
    localparam logic [1:0] CASE_ZERO    = 2'd1;
    localparam logic [1:0] CASE_ALIGNED = 2'd2;
    localparam logic [1:0] CASE_ANTI    = 2'd3;

    // pipeline geometry
    localparam int SQ1_N   = 31;  // bits of the first root
    localparam int SQ2_N   = 32;  // bits of the second root
    localparam int DIV_N   = 31;  // quotient bits of every divide
    localparam int SIDE_N  = 69;  // scaled vector, from the scale stage to the numerator stage
    localparam int SIDE_AT_LEN  = 33;
    localparam int SIDE_AT_CMAG = 64;
    localparam int QW_N    = 35;
    localparam int DEC_N   = 36;
    localparam int FLG_N   = 32;
    localparam int DEPTH   = 105;

    typedef struct packed {
        logic [29:0] ax;
        logic [29:0] ay;
        logic [29:0] az;
        logic        nx;
        logic        ny;
        logic        nz;
        logic        zero;
    } t_side;

    typedef struct packed {
        logic zero;
        logic nrmz;
        logic ny;
        logic nz;
    } t_flags;

    typedef struct packed {
        logic aligned;
        logic anti;
    } t_dec;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] root;
    } t_sqrt_st;

    typedef struct packed {
        logic [63:0] rem;
        logic [30:0] quo;
    } t_div_st;

    // one bit of a restoring square root, rem holds n - root^2
    function automatic t_sqrt_st sqrt_step(input t_sqrt_st st, input int bitpos);
        logic [63:0] trial;
        t_sqrt_st    o;
        trial = ({32'd0, st.root} << (bitpos + 1)) | (64'd1 << (2 * bitpos));
        o = st;
        if (st.rem >= trial) begin
            o.rem  = st.rem - trial;
            o.root = st.root | (32'd1 << bitpos);
        end
        return o;
    endfunction

    // one bit of a restoring divide
    function automatic t_div_st div_step(input t_div_st st, input logic [31:0] d,
                                         input int bitpos);
        logic [63:0] sub;
        t_div_st     o;
        sub = {32'd0, d} << bitpos;
        o = st;
        if (st.rem >= sub) begin
            o.rem = st.rem - sub;
            o.quo = st.quo | (31'd1 << bitpos);
        end
        return o;
    endfunction

    // signed q2.30 from a magnitude quotient, saturated at one
    function automatic logic [31:0] signed_unit(input logic [30:0] q, input logic neg);
        logic [31:0] v;
        v = (q > ONE_Q30[30:0]) ? ONE_Q30 : {1'b0, q};
        return neg ? (32'd0 - v) : v;
    endfunction

endpackage
`default_nettype wire

### design/shortest_arc_quaternion_from_x_top.sv
// shortest_arc_quaternion_from_x_top: pipelined unit quaternion that turns +x onto tip - base
// depends on saq_pkg
// throughput: one word per cycle while the output word is not stalled
// the restoring root and divide chains give one bit per stage
// the whole pipe advances together and freezes while the output word waits on tready
// reset (i_rst_n low, synchronous) clears the valid bits only; data registers keep garbage
`default_nettype none
module shortest_arc_quaternion_from_x_top
    import saq_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // base_x, base_y, base_z, tip_x, tip_y, tip_z, 32 bits each from bit 0
    input  wire logic [191:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, 32 bits each from bit 0
    output logic [127:0]      o_m_axis_tdata,
    // case_code
    output logic [1:0]        o_m_axis_tuser
);

    // global advance: the pipe moves unless the output word is stuck
    logic en;
    logic [DEPTH-1:0] r_vld;

    assign en              = !r_vld[DEPTH-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_s_axis_tvalid};
        end
    end

    // stage 1: exact 33-bit differences
    logic signed [32:0] r_dx, r_dy, r_dz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx <= $signed({i_s_axis_tdata[127], i_s_axis_tdata[127:96]})
                  - $signed({i_s_axis_tdata[31], i_s_axis_tdata[31:0]});
            r_dy <= $signed({i_s_axis_tdata[159], i_s_axis_tdata[159:128]})
                  - $signed({i_s_axis_tdata[63], i_s_axis_tdata[63:32]});
            r_dz <= $signed({i_s_axis_tdata[191], i_s_axis_tdata[191:160]})
                  - $signed({i_s_axis_tdata[95], i_s_axis_tdata[95:64]});
        end
    end

    // stage 2: magnitudes and signs
    logic [32:0] r_mx, r_my, r_mz;
    logic        r_nx2, r_ny2, r_nz2, r_zero2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mx    <= r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
            r_my    <= r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
            r_mz    <= r_dz[32] ? 33'(-r_dz) : 33'(r_dz);
            r_nx2   <= r_dx[32];
            r_ny2   <= r_dy[32];
            r_nz2   <= r_dz[32];
            r_zero2 <= (r_dx == '0) && (r_dy == '0) && (r_dz == '0);
        end
    end

    // stage 3: leading one of the largest magnitude
    logic [32:0] n_max;
    logic [5:0]  n_msb;
    always_comb begin
        n_max = r_mx;
        if (r_my > n_max) n_max = r_my;
        if (r_mz > n_max) n_max = r_mz;
        n_msb = '0;
        for (int i = 0; i < 33; i++) begin
            if (n_max[i]) n_msb = 6'(i);
        end
    end

    logic [32:0] r_mx3, r_my3, r_mz3;
    logic [5:0]  r_msb;
    logic        r_nx3, r_ny3, r_nz3, r_zero3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mx3   <= r_mx;
            r_my3   <= r_my;
            r_mz3   <= r_mz;
            r_msb   <= n_msb;
            r_nx3   <= r_nx2;
            r_ny3   <= r_ny2;
            r_nz3   <= r_nz2;
            r_zero3 <= r_zero2;
        end
    end

    // stage 4: common shift so the largest lands in [2^29, 2^30)
    logic        n_right;
    logic [5:0]  n_amt;
    logic [32:0] n_sx, n_sy, n_sz;
    always_comb begin
        n_right = r_msb > 6'd29;
        n_amt   = n_right ? (r_msb - 6'd29) : (6'd29 - r_msb);
        n_sx    = n_right ? (r_mx3 >> n_amt) : (r_mx3 << n_amt);
        n_sy    = n_right ? (r_my3 >> n_amt) : (r_my3 << n_amt);
        n_sz    = n_right ? (r_mz3 >> n_amt) : (r_mz3 << n_amt);
    end

    t_side r_side [0:SIDE_N-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= '{ax: n_sx[29:0], ay: n_sy[29:0], az: n_sz[29:0],
                           nx: r_nx3, ny: r_ny3, nz: r_nz3, zero: r_zero3};
        end
    end
    for (genvar j = 1; j < SIDE_N; j++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (en) r_side[j] <= r_side[j-1];
        end
    end

    // stages 5 and 6: squared length of the scaled vector
    logic [59:0] r_sqx, r_sqy, r_sqz;
    logic [63:0] r_s2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqx <= {30'd0, r_side[0].ax} * {30'd0, r_side[0].ax};
            r_sqy <= {30'd0, r_side[0].ay} * {30'd0, r_side[0].ay};
            r_sqz <= {30'd0, r_side[0].az} * {30'd0, r_side[0].az};
            r_s2  <= {4'd0, r_sqx} + {4'd0, r_sqy} + {4'd0, r_sqz};
        end
    end

    // first root: one bit per stage gives the length
    t_sqrt_st r_sq1 [0:SQ1_N-1];
    for (genvar k = 0; k < SQ1_N; k++) begin : g_sq1
        t_sqrt_st n_st;
        if (k == 0) begin : g_first
            assign n_st = sqrt_step('{rem: r_s2, root: 32'd0}, SQ1_N - 1);
        end else begin : g_rest
            assign n_st = sqrt_step(r_sq1[k-1], SQ1_N - 1 - k);
        end
        always_ff @(posedge i_clk) begin
            if (en) r_sq1[k] <= n_st;
        end
    end

    logic [31:0] len;
    t_side       side_len;
    assign len      = r_sq1[SQ1_N-1].root;
    assign side_len = r_side[SIDE_AT_LEN];

    // cosine magnitude divide: ax * 2^30 / len, divisor carried beside each step
    t_div_st     r_dc  [0:DIV_N-1];
    logic [31:0] r_dcd [0:DIV_N-1];
    for (genvar k = 0; k < DIV_N; k++) begin : g_divc
        t_div_st n_st;
        if (k == 0) begin : g_first
            assign n_st = div_step('{rem: {4'd0, side_len.ax, 30'd0}, quo: 31'd0},
                                   len, DIV_N - 1);
            always_ff @(posedge i_clk) begin
                if (en) r_dcd[k] <= len;
            end
        end else begin : g_rest
            assign n_st = div_step(r_dc[k-1], r_dcd[k-1], DIV_N - 1 - k);
            always_ff @(posedge i_clk) begin
                if (en) r_dcd[k] <= r_dcd[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) r_dc[k] <= n_st;
        end
    end

    // near-parallel decision, then carried to the output stage
    t_dec  r_dec [0:DEC_N-1];
    t_side side_c;
    logic  n_over;
    assign side_c = r_side[SIDE_AT_CMAG];
    assign n_over = (side_c.ax != '0) && (r_dc[DIV_N-1].quo > COS_LIMIT);
    always_ff @(posedge i_clk) begin
        if (en) r_dec[0] <= '{aligned: n_over && !side_c.nx, anti: n_over && side_c.nx};
    end
    for (genvar j = 1; j < DEC_N; j++) begin : g_dec
        always_ff @(posedge i_clk) begin
            if (en) r_dec[j] <= r_dec[j-1];
        end
    end

    // general path: w term, its norm
    logic [31:0] r_qw [0:QW_N-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qw[0] <= side_len.nx ? (len - {2'd0, side_len.ax})
                                   : (len + {2'd0, side_len.ax});
        end
    end
    for (genvar j = 1; j < QW_N; j++) begin : g_qw
        always_ff @(posedge i_clk) begin
            if (en) r_qw[j] <= r_qw[j-1];
        end
    end

    logic [63:0] r_qw2;
    logic [59:0] r_qy2, r_qz2;
    logic [63:0] r_qsum;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qw2  <= {32'd0, r_qw[0]} * {32'd0, r_qw[0]};
            r_qy2  <= {30'd0, r_side[SIDE_AT_LEN+1].ay} * {30'd0, r_side[SIDE_AT_LEN+1].ay};
            r_qz2  <= {30'd0, r_side[SIDE_AT_LEN+1].az} * {30'd0, r_side[SIDE_AT_LEN+1].az};
            r_qsum <= r_qw2 + {4'd0, r_qy2} + {4'd0, r_qz2};
        end
    end

    t_sqrt_st r_sq2 [0:SQ2_N-1];
    for (genvar k = 0; k < SQ2_N; k++) begin : g_sq2
        t_sqrt_st n_st;
        if (k == 0) begin : g_first
            assign n_st = sqrt_step('{rem: r_qsum, root: 32'd0}, SQ2_N - 1);
        end else begin : g_rest
            assign n_st = sqrt_step(r_sq2[k-1], SQ2_N - 1 - k);
        end
        always_ff @(posedge i_clk) begin
            if (en) r_sq2[k] <= n_st;
        end
    end

    // numerators with half the norm added for rounding
    logic [31:0] nrm;
    t_side       side_n;
    logic [63:0] n_half;
    assign nrm    = r_sq2[SQ2_N-1].root;
    assign side_n = r_side[SIDE_N-1];
    assign n_half = {33'd0, nrm[31:1]};

    logic [63:0] r_numy, r_numz, r_numw;
    logic [31:0] r_nrm;
    t_flags      r_flg [0:FLG_N-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_numy   <= {4'd0, side_n.az, 30'd0} + n_half;
            r_numz   <= {4'd0, side_n.ay, 30'd0} + n_half;
            r_numw   <= {2'd0, r_qw[QW_N-1], 30'd0} + n_half;
            r_nrm    <= nrm;
            r_flg[0] <= '{zero: side_n.zero, nrmz: nrm == '0,
                          ny: side_n.ny, nz: side_n.nz};
        end
    end
    for (genvar j = 1; j < FLG_N; j++) begin : g_flg
        always_ff @(posedge i_clk) begin
            if (en) r_flg[j] <= r_flg[j-1];
        end
    end

    // three component divides share one divisor line
    t_div_st     r_dy3 [0:DIV_N-1];
    t_div_st     r_dz3 [0:DIV_N-1];
    t_div_st     r_dw3 [0:DIV_N-1];
    logic [31:0] r_dn  [0:DIV_N-1];
    for (genvar k = 0; k < DIV_N; k++) begin : g_divq
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dy3[k] <= div_step('{rem: r_numy, quo: 31'd0}, r_nrm, DIV_N - 1);
                    r_dz3[k] <= div_step('{rem: r_numz, quo: 31'd0}, r_nrm, DIV_N - 1);
                    r_dw3[k] <= div_step('{rem: r_numw, quo: 31'd0}, r_nrm, DIV_N - 1);
                    r_dn[k]  <= r_nrm;
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dy3[k] <= div_step(r_dy3[k-1], r_dn[k-1], DIV_N - 1 - k);
                    r_dz3[k] <= div_step(r_dz3[k-1], r_dn[k-1], DIV_N - 1 - k);
                    r_dw3[k] <= div_step(r_dw3[k-1], r_dn[k-1], DIV_N - 1 - k);
                    r_dn[k]  <= r_dn[k-1];
                end
            end
        end
    end

    // output stage: path select and saturation
    t_flags      fl;
    t_dec        dc;
    logic [31:0] n_qx, n_qy, n_qz, n_qw;
    logic [1:0]  n_code;
    assign fl = r_flg[FLG_N-1];
    assign dc = r_dec[DEC_N-1];
    always_comb begin
        n_qx   = '0;
        n_qy   = '0;
        n_qz   = '0;
        n_qw   = ONE_Q30;
        n_code = CASE_GENERAL;
        if (fl.zero) begin
            n_code = CASE_ZERO;
        end else if (dc.aligned) begin
            n_code = CASE_ALIGNED;
        end else if (dc.anti) begin
            n_qy   = ONE_Q30;
            n_qw   = '0;
            n_code = CASE_ANTI;
        end else if (!fl.nrmz) begin
            n_qy = signed_unit(r_dy3[DIV_N-1].quo, !fl.nz);
            n_qz = signed_unit(r_dz3[DIV_N-1].quo, fl.ny);
            n_qw = signed_unit(r_dw3[DIV_N-1].quo, 1'b0);
        end
    end

    logic [127:0] r_tdata;
    logic [1:0]   r_tuser;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tdata <= {n_qw, n_qz, n_qy, n_qx};
            r_tuser <= n_code;
        end
    end
    assign o_m_axis_tdata = r_tdata;
    assign o_m_axis_tuser = r_tuser;

endmodule
`default_nettype wire

### design/saq_chk.sv
// saq_chk: port-level checks on the shortest-arc quaternion top level, bound in below
// depends on saq_pkg
`default_nettype none
module saq_chk
    import saq_pkg::*;
(
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic [191:0] i_s_axis_tdata,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [127:0] o_m_axis_tdata,
    input wire logic [1:0]   o_m_axis_tuser
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output word valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled output word changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    a_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == CASE_ZERO || o_m_axis_tuser == CASE_ALIGNED)
            |-> o_m_axis_tdata == {ONE_Q30, 96'd0})
        else $error("identity path word wrong");

    a_anti: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == CASE_ANTI
            |-> o_m_axis_tdata == {64'd0, ONE_Q30, 32'd0})
        else $error("half turn word wrong");

endmodule

bind shortest_arc_quaternion_from_x_top saq_chk u_saq_chk (.*);
`default_nettype wire

### tb/tb_shortest_arc_quaternion_from_x_top.sv
// tb_shortest_arc_quaternion_from_x_top: self-checking bench for the shortest-arc quaternion pipe
// drives random and directed point pairs, predicts each quaternion word bit-exactly in a scoreboard
// depends on saq_pkg and shortest_arc_quaternion_from_x_top
`timescale 1ns / 1ps
`default_nettype none

// scoreboard: turns each accepted point pair into the expected quaternion word
class quat_scoreboard;
    typedef struct packed {
        logic [31:0] qx;
        logic [31:0] qy;
        logic [31:0] qz;
        logic [31:0] qw;
        logic [1:0]  code;
    } t_quat;

    t_quat pending_quats[$];
    int    n_errors;

    function new();
        n_errors = 0;
    endfunction

    static function logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // rounded half away from zero, saturated at one
    static function logic [31:0] unit_part(input logic [63:0] mag, input bit neg,
                                           input logic [63:0] n);
        logic [63:0] q;
        q = ((mag << 30) + (n >> 1)) / n;
        if (q > 64'd1073741824) q = 64'd1073741824;
        return neg ? 32'(-q) : q[31:0];
    endfunction

    // note an accepted input word
    function void note_points(input logic [191:0] pts);
        t_quat e;
        logic signed [32:0] dx, dy, dz;
        logic [63:0] ax, ay, az, m, len, cmag, qw, nrm;
        dx = $signed(pts[127:96]) - $signed(pts[31:0]);
        dy = $signed(pts[159:128]) - $signed(pts[63:32]);
        dz = $signed(pts[191:160]) - $signed(pts[95:64]);
        e = '{32'd0, 32'd0, 32'd0, saq_pkg::ONE_Q30, saq_pkg::CASE_ZERO};
        if (dx != 0 || dy != 0 || dz != 0) begin
            ax = dx < 0 ? 64'(-dx) : 64'(dx);
            ay = dy < 0 ? 64'(-dy) : 64'(dy);
            az = dz < 0 ? 64'(-dz) : 64'(dz);
            m = ax;
            if (ay > m) m = ay;
            if (az > m) m = az;
            // common scale so the largest magnitude sits in [2^29, 2^30)
            while (m >= 64'd1 << 30) begin
                m = m >> 1; ax = ax >> 1; ay = ay >> 1; az = az >> 1;
            end
            while (m < 64'd1 << 29) begin
                m = m << 1; ax = ax << 1; ay = ay << 1; az = az << 1;
            end
            len = int_sqrt(ax * ax + ay * ay + az * az);
            cmag = (ax << 30) / len;
            if (ax != 0 && cmag > 64'(saq_pkg::COS_LIMIT)) begin
                if (dx < 0) e = '{32'd0, saq_pkg::ONE_Q30, 32'd0, 32'd0, saq_pkg::CASE_ANTI};
                else e.code = saq_pkg::CASE_ALIGNED;
            end else begin
                qw = dx < 0 ? len - ax : len + ax;
                nrm = int_sqrt(qw * qw + ay * ay + az * az);
                e.code = saq_pkg::CASE_GENERAL;
                if (nrm != 0) begin
                    e.qy = unit_part(az, !(dz < 0), nrm);
                    e.qz = unit_part(ay, dy < 0, nrm);
                    e.qw = unit_part(qw, 1'b0, nrm);
                end
            end
        end
        pending_quats.push_back(e);
    endfunction

    // check an accepted output word against the oldest expectation
    function void check_quat(input logic [127:0] data, input logic [1:0] code);
        t_quat e;
        if (pending_quats.size() == 0) begin
            $error("unexpected output word %h", data);
            n_errors++;
            return;
        end
        e = pending_quats.pop_front();
        if (data[31:0] !== e.qx) begin
            $error("quat_x expected %h got %h", e.qx, data[31:0]); n_errors++;
        end
        if (data[63:32] !== e.qy) begin
            $error("quat_y expected %h got %h", e.qy, data[63:32]); n_errors++;
        end
        if (data[95:64] !== e.qz) begin
            $error("quat_z expected %h got %h", e.qz, data[95:64]); n_errors++;
        end
        if (data[127:96] !== e.qw) begin
            $error("quat_w expected %h got %h", e.qw, data[127:96]); n_errors++;
        end
        if (code !== e.code) begin
            $error("case_code expected %0d got %0d", e.code, code); n_errors++;
        end
    endfunction
endclass

module tb_shortest_arc_quaternion_from_x_top;
    import saq_pkg::*;

    localparam int LATENCY   = 105;
    localparam int N_RANDOM  = 630;
    localparam int CYCLE_CAP = 200000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;   // base_x, base_y, base_z, tip_x, tip_y, tip_z from bit 0
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // quat_x, quat_y, quat_z, quat_w from bit 0
    logic [1:0]   m_tuser;   // case_code

    quat_scoreboard quat_sb;
    bit             calm_tail;  // no idling in the last part of the run
    int             cycle_count;

    shortest_arc_quaternion_from_x_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // monitor: note accepted inputs, check accepted outputs, watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && s_tvalid && s_tready) quat_sb.note_points(s_tdata);
        if (i_rst_n && m_tvalid && m_tready) quat_sb.check_quat(m_tdata, m_tuser);
        if (cycle_count > CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stall bursts on tready
    initial begin
        m_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            @(negedge i_clk);
            if (!calm_tail && $urandom_range(0, 9) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end
            m_tready = 1'b1;
        end
    end

    // present one word and hold it until accepted; optional gap first
    task automatic send_points(input logic [191:0] pts);
        if (!calm_tail && $urandom_range(0, 9) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = pts;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_pair(input logic [31:0] bx, by, bz, tx, ty, tz);
        send_points({tz, ty, tx, bz, by, bx});
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 200)) - 100);
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        endcase
    endfunction

    task automatic send_random();
        logic [31:0] bx, by, bz, dx, dy, dz;
        bx = rand_coord(); by = rand_coord(); bz = rand_coord();
        case ($urandom_range(0, 7))
            0: send_pair(bx, by, bz, bx, by, bz);                     // zero length
            1: begin                                                  // near +x or -x
                dx = $urandom_range(0, 1) ? 32'h4000_0000 : 32'hc000_0000;
                dy = 32'($signed($urandom_range(0, 4000)) - 2000);
                dz = 32'($signed($urandom_range(0, 4000)) - 2000);
                send_pair(bx, by, bz, bx + dx, by + dy, bz + dz);
            end
            2: begin                                                  // tiny offsets
                dx = 32'($signed($urandom_range(0, 4)) - 2);
                dy = 32'($signed($urandom_range(0, 4)) - 2);
                dz = 32'($signed($urandom_range(0, 4)) - 2);
                send_pair(bx, by, bz, bx + dx, by + dy, bz + dz);
            end
            default: send_pair(bx, by, bz, rand_coord(), rand_coord(), rand_coord());
        endcase
    endtask

    initial begin
        quat_sb     = new();
        calm_tail   = 1'b0;
        cycle_count = 0;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero length, axis directions, extremes, cosine limits
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(32'h7fff_ffff, 32'h8000_0000, 5, 32'h7fff_ffff, 32'h8000_0000, 5);
        send_pair(0, 0, 0, 32'h0001_0000, 0, 0);              // aligned
        send_pair(0, 0, 0, 32'hffff_0000, 0, 0);              // anti-parallel
        send_pair(0, 0, 0, 0, 32'h0001_0000, 0);              // +y
        send_pair(0, 0, 0, 0, 0, 32'hffff_0000);              // -z
        send_pair(0, 0, 0, 0, 32'hffff_ffff, 0);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_pair(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0);
        send_pair(32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0);
        send_pair(0, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 0);
        send_pair(0, 0, 0, 32'h4000_0000, 32'd1510000, 0);    // just over the cosine limit
        send_pair(0, 0, 0, 32'h4000_0000, 32'd1530000, 0);    // just under it
        send_pair(0, 0, 0, 32'hc000_0000, 0, 32'd1510000);
        send_pair(0, 0, 0, 32'hc000_0000, 0, 32'd1530000);
        send_pair(0, 0, 0, 32'hffff_ffff, 32'd1, 32'd1);
        send_pair(32'h1234_5678, 32'hfedc_ba98, 32'h0f0f_0f0f,
                  32'hedcb_a987, 32'h0123_4567, 32'hf0f0_f0f0);

        // hold off until the pipe has drained
        s_tvalid = 1'b0;
        while (quat_sb.pending_quats.size() != 0) @(negedge i_clk);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 80) calm_tail = 1'b1;
            send_random();
        end
        s_tvalid = 1'b0;

        while (quat_sb.pending_quats.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
        if (quat_sb.n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

`default_nettype wire
